FILE: rtl/psk_extension_parser_assert.svh
// Assertion macros shared by the PSK extension parser RTL.
`ifndef PSK_EXTENSION_PARSER_ASSERT_SVH
`define PSK_EXTENSION_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define PSK_ASSERT_HOLDS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Checks a property over time, written with an implication operator.
`define PSK_ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define PSK_ASSERT_HOLDS(label, clk, rst, expr, msg)
`define PSK_ASSERT_PROP(label, clk, rst, prop, msg)
`endif

`endif

FILE: rtl/psk_pkg.sv
// Package with the types and constants of the PSK extension parser.
`default_nettype none

package psk_pkg;

  // Widths of the stream words.
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 64;

  // Byte counter width and its saturation value.
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Extension type code of the PSK extension.
  localparam logic [15:0] PSK_TYPE = 16'h0029;

  // Byte offsets of the captured fields; the age and binder offsets also count the identity length.
  localparam logic [CNT_W-1:0] TYPE_END   = 17'd2;
  localparam logic [CNT_W-1:0] BODY_END   = 17'd4;
  localparam logic [CNT_W-1:0] IDLEN_HI   = 17'd6;
  localparam logic [CNT_W-1:0] IDLEN_LO   = 17'd7;
  localparam logic [CNT_W-1:0] AGE_FIRST  = 17'd8;
  localparam logic [CNT_W-1:0] AGE_LAST   = 17'd11;
  localparam logic [CNT_W-1:0] BINDER_OFS = 17'd14;

  // Constants of the length checks.
  localparam logic [CNT_W-1:0] HDR_LEN    = 17'd4;
  localparam logic [CNT_W-1:0] MIN_TAIL   = 17'd15;
  localparam logic [CNT_W-1:0] BODY_FIXED = 17'd11;

  // One input word held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } psk_item_t;

  // One parse result.
  typedef struct packed {
    logic [7:0]  binder_size;
    logic [31:0] obf_age;
    logic [15:0] identity_length;
    logic        ok;
  } psk_result_t;

endpackage

`default_nettype wire

FILE: rtl/psk_in_reg.sv
// Input register of the parser: holds one accepted word until the capture stage takes it.
`default_nettype none

module psk_in_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [psk_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
  input  wire logic                          s_tlast,  // last
  input  wire logic                          advance,
  output logic                               held_valid,
  output psk_pkg::psk_item_t                 held_item
);
  import psk_pkg::*;

  logic take;

  // A new word may enter when the register is empty or drains this cycle.
  assign s_tready = !held_valid || advance;
  assign take     = s_tvalid && s_tready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      held_item.data_byte <= s_tdata;
      held_item.last      <= s_tlast;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psk_capture.sv
// Byte counter, field capture registers and the well-formedness checks.
`default_nettype none

module psk_capture (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire psk_pkg::psk_item_t item,
  output psk_pkg::psk_result_t    result
);
  import psk_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      type_field, type_field_next;
  logic [15:0]      body_length, body_length_next;
  logic [15:0]      ident_len_reg, ident_len_reg_next;
  logic [31:0]      age_reg, age_reg_next;
  logic [7:0]       bsize_reg, bsize_reg_next;

  logic [CNT_W-1:0] ident_wide;
  logic [CNT_W-1:0] body_wide;
  logic [CNT_W-1:0] len_sum;
  logic             in_age;
  logic             is_binder;
  logic             ok;

  // Offsets that move with the identity length.
  assign ident_wide = {1'b0, ident_len_reg};
  assign in_age     = (byte_count >= ident_wide + AGE_FIRST) &&
                      (byte_count <= ident_wide + AGE_LAST);
  assign is_binder  = (byte_count == ident_wide + BINDER_OFS);

  // Capture of the current byte at its offset; the counter saturates.
  always_comb begin
    type_field_next    = type_field;
    body_length_next   = body_length;
    ident_len_reg_next = ident_len_reg;
    age_reg_next       = age_reg;
    bsize_reg_next     = bsize_reg;
    if (byte_count < TYPE_END) begin
      type_field_next = {type_field[7:0], item.data_byte};
    end else if (byte_count < BODY_END) begin
      body_length_next = {body_length[7:0], item.data_byte};
    end else if (byte_count == IDLEN_HI || byte_count == IDLEN_LO) begin
      ident_len_reg_next = {ident_len_reg[7:0], item.data_byte};
    end else if (in_age) begin
      age_reg_next = {age_reg[23:0], item.data_byte};
    end else if (is_binder) begin
      bsize_reg_next = item.data_byte;
    end
    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 17'd1;
  end

  // Length checks on the values that include the current byte.
  assign body_wide = {1'b0, body_length_next};
  assign len_sum   = {1'b0, ident_len_reg_next} + {9'd0, bsize_reg_next};
  assign ok = (type_field_next == PSK_TYPE) &&
              (body_wide + HDR_LEN <= byte_count_next) &&
              (byte_count_next >= len_sum + MIN_TAIL) &&
              (body_wide == len_sum + BODY_FIXED);

  // A malformed offer reports all fields as zero.
  always_comb begin
    result.ok              = ok;
    result.identity_length = ok ? ident_len_reg_next : 16'd0;
    result.obf_age         = ok ? age_reg_next : 32'd0;
    result.binder_size     = ok ? bsize_reg_next : 8'd0;
  end

  // Parse state; the last word of a buffer clears it for the next one.
  always_ff @(posedge clk) begin
    if (rst || (advance && item.last)) begin
      byte_count    <= '0;
      type_field    <= '0;
      body_length   <= '0;
      ident_len_reg <= '0;
      age_reg       <= '0;
      bsize_reg     <= '0;
    end else if (advance) begin
      byte_count    <= byte_count_next;
      type_field    <= type_field_next;
      body_length   <= body_length_next;
      ident_len_reg <= ident_len_reg_next;
      age_reg       <= age_reg_next;
      bsize_reg     <= bsize_reg_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psk_out_reg.sv
// Result register driving the master side of the stream.
`default_nettype none

module psk_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire psk_pkg::psk_result_t          result,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] ok, [16:1] identity_length, [48:17] obf_age, [56:49] binder_size,
  // [63:57] zero
  output logic [psk_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                               free
);
  import psk_pkg::*;

  psk_result_t held;

  // The slot can take a result when empty or when its word leaves now.
  assign free = !m_tvalid || m_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  // Pack fields from the lowest bit up, pad to whole bytes.
  assign m_tdata = {{(M_TDATA_W - $bits(psk_result_t)){1'b0}}, held};

endmodule

`default_nettype wire

FILE: rtl/psk_extension_parser.sv
// Top level of the TLS 1.3 PSK extension parser.
//
//   Channel  Direction  Word                         Fields in tdata, lowest bit first
//   s_*      in         one extension byte           data_byte[7:0]; tlast = last
//   m_*      out        one parse result per buffer  ok, identity_length,
//                                                    obf_age, binder_size
//
// An accepted byte sits in the input register and is counted and captured as it
// advances; a closing byte loads its result into the output register at that edge,
// so m_tvalid rises once the closing byte leaves the input register. One byte is
// taken per cycle unless a closing byte stalls; the output register decouples the
// two sides. A stalled master holds only a last byte in the input register.
// Synchronous active-high reset clears the counter and all captured fields.
`default_nettype none

module psk_extension_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [psk_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
  input  wire logic                          s_tlast,  // last
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] ok, [16:1] identity_length, [48:17] obf_age, [56:49] binder_size,
  // [63:57] zero
  output logic [psk_pkg::M_TDATA_W-1:0]      m_tdata
);
  import psk_pkg::*;

`include "psk_extension_parser_assert.svh"

  logic        held_valid;
  psk_item_t   held_item;
  psk_result_t result;
  logic        out_free;
  logic        advance;
  logic        load;
  logic        res_clean;
  logic        close_stuck;
  logic        mid_held;

  // A held byte moves on unless it closes a buffer and the result slot is busy.
  assign advance = held_valid && (!held_item.last || out_free);
  assign load    = advance && held_item.last;

  psk_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  psk_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .result  (result)
  );

  psk_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .free     (out_free)
  );

  // Conditions watched by the assertions below.
  assign res_clean   = m_tdata[0] || (m_tdata[56:1] == 56'd0);
  assign close_stuck = held_valid && held_item.last && !out_free;
  assign mid_held    = held_valid && !held_item.last;

  // A malformed result carries zero fields.
  `PSK_ASSERT_HOLDS(a_bad_is_zero, clk, rst, !m_tvalid || res_clean, "bad result has nonzero fields")

  // A closing byte cannot pass a stalled result, so the input side must stall.
  `PSK_ASSERT_PROP(a_stall_back, clk, rst, close_stuck |-> !s_tready, "closing byte overtaken")

  // Every closing byte that advances shows up as a valid result next cycle.
  `PSK_ASSERT_PROP(a_result_out, clk, rst, load |=> m_tvalid, "closing byte produced no result")

  // Bytes that do not close a buffer never wait in the input register.
  `PSK_ASSERT_PROP(a_flow_mid, clk, rst, mid_held |-> advance, "middle byte stalled")

endmodule

`default_nettype wire
